FILE: rtl/core/plc_pkg.sv
// Shared widths, constants and item types of the piecewise linear calibration block.
package plc_pkg;

   // table size
   localparam int POINT_COUNT_DEFAULT = 16;

   // field widths
   localparam int UM_W    = 17;
   localparam int IDX_W   = 4;
   localparam int STEPS_W = 14;
   localparam int COUNT_W = 32;

   // depth limit for stored points and register reset value
   localparam logic [UM_W-1:0]    UM_LIMIT    = 17'd100000;
   localparam logic [STEPS_W-1:0] STEPS_RESET = 14'd32;

   // segment number: floor(depth / 500) = floor((depth >> 2) * SEG_RECIP >> SEG_SHIFT)
   localparam int              SEG_W      = 9;
   localparam int              RECIP_W    = 16;
   localparam int              QUARTER_W  = UM_W - 2;
   localparam int              SEG_PROD_W = QUARTER_W + RECIP_W;
   localparam int              SEG_SHIFT  = 22;
   localparam logic [RECIP_W-1:0] SEG_RECIP = 16'd33555;

   // datapath widths
   localparam int DIFF_W = UM_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int MAG_W  = SUM_W - 1;
   localparam int NUM_W  = MAG_W + STEPS_W;
   localparam int DEN_W  = 24;

   localparam logic [DEN_W-1:0] PERCENT = 24'd100;

   // saturation bounds
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'h7FFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MIN = 32'h8000_0000;

   typedef enum logic {
      OP_CONVERT = 1'b0,
      OP_WRITE   = 1'b1
   } op_type;

   typedef logic [STEPS_W-1:0] steps_type;

   typedef struct packed {
      op_type           operation;
      logic [IDX_W-1:0] point_index;
      logic [UM_W-1:0]  standard_um;
      logic [UM_W-1:0]  measured_um;
      logic [UM_W-1:0]  depth_um;
   } req_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] step_count;
      logic                      used_fallback;
      logic                      saturated;
   } rsp_type;

   // one calibration point
   typedef struct packed {
      logic [UM_W-1:0] standard_um;
      logic [UM_W-1:0] measured_um;
   } entry_type;

   // item flags that ride along with the divider
   typedef struct packed {
      logic neg;
      logic active;
      logic fallback;
   } side_type;

endpackage

FILE: rtl/core/plc_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
interface plc_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

FILE: rtl/core/piecewise_linear_calibration.sv
// Top level: depth calibration table and pipelined depth-to-steps conversion.
//
// req_if carries one item per valid/ready handshake: a point write (operation 1)
// stores standard and measured depth at point_index, a conversion (operation 0)
// turns depth_um into a motor step count. Every item yields exactly one rsp_if
// item, in order; writes answer with zeros. csr_if writes steps_per_depth and is
// always ready; write it only while no item is in flight.
// Throughput: one item per cycle while rsp_if does not stall. An item passes six
// stages (input register, segment lookup, differences, products, sum, magnitude),
// then the divider's load register and its 50-stage quotient pipeline (one bit per stage).
// Table reads happen in order with writes, so a conversion right behind a write
// sees the new point.
// Reset empties the pipeline, marks every table point as zero and loads
// steps_per_depth with 32.
// When the receiver stalls, the output register holds its item and one more
// item drops into a skid register; then the whole pipeline freezes and req_if
// ready falls until the skid register drains. Nothing is lost or repeated.
module piecewise_linear_calibration #(
   parameter int POINT_COUNT = plc_pkg::POINT_COUNT_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   plc_chan_if.sink      req_if,
   plc_chan_if.source    rsp_if,
   plc_chan_if.sink      csr_if
);

   localparam int UM_W    = plc_pkg::UM_W;
   localparam int DIFF_W  = plc_pkg::DIFF_W;
   localparam int PROD_W  = plc_pkg::PROD_W;
   localparam int SUM_W   = plc_pkg::SUM_W;
   localparam int MAG_W   = plc_pkg::MAG_W;
   localparam int NUM_W   = plc_pkg::NUM_W;
   localparam int DEN_W   = plc_pkg::DEN_W;
   localparam int SEG_W   = plc_pkg::SEG_W;
   localparam int STEPS_W = plc_pkg::STEPS_W;
   localparam int COUNT_W = plc_pkg::COUNT_W;
   localparam int AW      = $clog2(POINT_COUNT);
   localparam int STAGES  = 6;

   localparam logic [SEG_W-1:0] SEG_ONE = SEG_W'(1);
   localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(POINT_COUNT - 1);

   // table lookup result
   typedef struct packed {
      logic                active;
      logic [UM_W-1:0]     depth;
   } s1_type;

   // differences
   typedef struct packed {
      logic                active;
      logic                flat;
      logic                dx_neg;
      logic signed [DIFF_W-1:0] dx;
      logic [UM_W-1:0]     dx_mag;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dd;
      logic [UM_W-1:0]     y1;
      logic [UM_W-1:0]     depth;
   } s2_type;

   // products
   typedef struct packed {
      logic                active;
      logic                flat;
      logic                dx_neg;
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
      logic [DEN_W-1:0]    den;
   } s3_type;

   // sum
   typedef struct packed {
      logic                active;
      logic                flat;
      logic                dx_neg;
      logic signed [SUM_W-1:0] sum;
      logic [DEN_W-1:0]    den;
   } s4_type;

   // magnitude and result sign
   typedef struct packed {
      plc_pkg::side_type   side;
      logic [MAG_W-1:0]    abs_sum;
      logic [DEN_W-1:0]    den;
   } s5_type;

   logic                   advance;
   logic [STAGES-1:0]      valid_ff;
   plc_pkg::steps_type     steps_ff;
   plc_pkg::req_type       s0_ff;
   s1_type                 s1_ff, s1_in;
   s2_type                 s2_ff, s2_in;
   s3_type                 s3_ff, s3_in;
   s4_type                 s4_ff, s4_in;
   s5_type                 s5_ff, s5_in;

   plc_pkg::entry_type     cal_mem [POINT_COUNT];
   logic [POINT_COUNT-1:0] point_ok_ff;
   plc_pkg::entry_type     lo_ff, hi_ff;
   logic                   lo_ok_ff, hi_ok_ff;

   logic [plc_pkg::SEG_PROD_W-1:0] seg_prod;
   logic [SEG_W-1:0]       seg_quot;
   logic [SEG_W-1:0]       seg_num;
   logic [AW-1:0]          lo_addr, hi_addr, wr_addr;
   logic                   wr_en;
   plc_pkg::entry_type     wr_entry;

   logic [UM_W-1:0]        x0, x1, y0, y1;

   logic [NUM_W-1:0]       div_num;
   logic                   div_valid;
   logic [NUM_W-1:0]       div_quot;
   plc_pkg::side_type      div_side;
   logic                   pos_over, neg_over;
   plc_pkg::rsp_type       done_item;

   plc_pkg::rsp_type       out_ff, out_in, skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                   out_take;

   // freeze the pipeline while the skid register holds an item
   assign advance      = !skid_valid_ff;
   assign req_if.ready = advance;
   assign csr_if.ready = 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= plc_pkg::STEPS_RESET;
      end else if (csr_if.valid) begin
         steps_ff <= csr_if.payload;
      end
   end

   // stage valid bits shift together
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-2:0], req_if.valid};
      end
   end

   // segment number and write decode from the registered item
   always_comb begin
      seg_prod = {{plc_pkg::RECIP_W{1'b0}}, s0_ff.depth_um[UM_W-1:2]}
               * {{plc_pkg::QUARTER_W{1'b0}}, plc_pkg::SEG_RECIP};
      seg_quot = seg_prod[plc_pkg::SEG_SHIFT +: SEG_W];
      seg_num  = (seg_quot <= SEG_ONE) ? SEG_ONE : seg_quot - SEG_ONE;
      if (seg_num > SEG_MAX) begin
         seg_num = SEG_MAX;
      end
      hi_addr = AW'(seg_num);
      lo_addr = AW'(seg_num - SEG_ONE);

      wr_addr  = AW'(s0_ff.point_index);
      wr_en    = advance && valid_ff[0] && (s0_ff.operation == plc_pkg::OP_WRITE)
                 && (int'(s0_ff.point_index) < POINT_COUNT);
      wr_entry.standard_um = (s0_ff.standard_um > plc_pkg::UM_LIMIT) ? '0 : s0_ff.standard_um;
      wr_entry.measured_um = (s0_ff.measured_um > plc_pkg::UM_LIMIT) ? '0 : s0_ff.measured_um;

      s1_in.active = (s0_ff.operation == plc_pkg::OP_CONVERT) && (s0_ff.depth_um != '0);
      s1_in.depth  = s0_ff.depth_um;
   end

   // calibration table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cal_mem[wr_addr] <= wr_entry;
      end
      if (advance) begin
         lo_ff <= cal_mem[lo_addr];
         hi_ff <= cal_mem[hi_addr];
      end
   end

   // per-point written marks; an unmarked point reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         point_ok_ff <= '0;
         lo_ok_ff    <= 1'b0;
         hi_ok_ff    <= 1'b0;
      end else if (advance) begin
         if (wr_en) begin
            point_ok_ff[wr_addr] <= 1'b1;
         end
         lo_ok_ff <= point_ok_ff[lo_addr];
         hi_ok_ff <= point_ok_ff[hi_addr];
      end
   end

   // differences along the segment
   always_comb begin
      x0 = lo_ok_ff ? lo_ff.measured_um : '0;
      y0 = lo_ok_ff ? lo_ff.standard_um : '0;
      x1 = hi_ok_ff ? hi_ff.measured_um : '0;
      y1 = hi_ok_ff ? hi_ff.standard_um : '0;

      s2_in.active = s1_ff.active;
      s2_in.dx     = $signed({1'b0, x1}) - $signed({1'b0, x0});
      s2_in.dy     = $signed({1'b0, y1}) - $signed({1'b0, y0});
      s2_in.dd     = $signed({1'b0, s1_ff.depth}) - $signed({1'b0, x1});
      s2_in.flat   = (x1 == x0);
      s2_in.dx_neg = s2_in.dx[DIFF_W-1];
      s2_in.dx_mag = s2_in.dx_neg ? UM_W'(-s2_in.dx) : UM_W'(s2_in.dx);
      s2_in.y1     = y1;
      s2_in.depth  = s1_ff.depth;
   end

   // products; a flat segment scales the depth by steps / 100 instead
   always_comb begin
      s3_in.active = s2_ff.active;
      s3_in.flat   = s2_ff.flat;
      s3_in.dx_neg = s2_ff.dx_neg;
      if (s2_ff.flat) begin
         s3_in.p1  = $signed({{(PROD_W-UM_W){1'b0}}, s2_ff.depth});
         s3_in.p2  = '0;
         s3_in.den = plc_pkg::PERCENT;
      end else begin
         s3_in.p1  = $signed({1'b0, s2_ff.y1}) * s2_ff.dx;
         s3_in.p2  = s2_ff.dy * s2_ff.dd;
         s3_in.den = {{(DEN_W-UM_W){1'b0}}, s2_ff.dx_mag} * plc_pkg::PERCENT;
      end
   end

   // sum of the two products
   always_comb begin
      s4_in.active = s3_ff.active;
      s4_in.flat   = s3_ff.flat;
      s4_in.dx_neg = s3_ff.dx_neg;
      s4_in.sum    = SUM_W'(s3_ff.p1) + SUM_W'(s3_ff.p2);
      s4_in.den    = s3_ff.den;
   end

   // magnitude and quotient sign
   always_comb begin
      s5_in.side.neg      = s4_ff.sum[SUM_W-1] ^ s4_ff.dx_neg;
      s5_in.side.active   = s4_ff.active;
      s5_in.side.fallback = s4_ff.active && s4_ff.flat;
      s5_in.abs_sum       = s4_ff.sum[SUM_W-1] ? MAG_W'(-s4_ff.sum) : MAG_W'(s4_ff.sum);
      s5_in.den           = s4_ff.den;
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= req_if.payload;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   // scale by steps_per_depth into the divider
   assign div_num = {{MAG_W{1'b0}}, steps_ff} * {{STEPS_W{1'b0}}, s5_ff.abs_sum};

   plc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (valid_ff[STAGES-1]),
      .in_num    (div_num),
      .in_den    (s5_ff.den),
      .in_side   (s5_ff.side),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // apply sign and clamp to the 32-bit range
   always_comb begin
      pos_over  = |div_quot[NUM_W-1:COUNT_W-1];
      neg_over  = (|div_quot[NUM_W-1:COUNT_W])
                  || (div_quot[COUNT_W-1] && (|div_quot[COUNT_W-2:0]));
      done_item = '0;
      if (div_side.active) begin
         done_item.used_fallback = div_side.fallback;
         if (div_side.neg) begin
            if (neg_over) begin
               done_item.step_count = $signed(plc_pkg::COUNT_MIN);
               done_item.saturated  = 1'b1;
            end else begin
               done_item.step_count = $signed(-div_quot[COUNT_W-1:0]);
            end
         end else begin
            if (pos_over) begin
               done_item.step_count = $signed(plc_pkg::COUNT_MAX);
               done_item.saturated  = 1'b1;
            end else begin
               done_item.step_count = $signed(div_quot[COUNT_W-1:0]);
            end
         end
      end
   end

   // output register with skid register behind it
   always_comb begin
      out_take      = !out_valid_ff || rsp_if.ready;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = div_valid;
            out_in        = done_item;
         end
      end else if (advance && div_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = done_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_ff;

endmodule

FILE: rtl/core/plc_divider.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module plc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [plc_pkg::NUM_W-1:0]     in_num,
   input  logic [plc_pkg::DEN_W-1:0]     in_den,
   input  plc_pkg::side_type             in_side,
   output logic                          out_valid,
   output logic [plc_pkg::NUM_W-1:0]     out_quot,
   output plc_pkg::side_type             out_side
);

   localparam int NUM_W = plc_pkg::NUM_W;
   localparam int DEN_W = plc_pkg::DEN_W;

   // partial remainder, numerator bits still to go with quotient bits shifted in
   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [NUM_W-1:0]  nq;
      logic [DEN_W-1:0]  den;
      plc_pkg::side_type side;
   } div_stage_type;

   logic [NUM_W:0] valid_ff;
   logic [NUM_W:0] valid_in;
   div_stage_type  stage_ff [NUM_W+1];
   div_stage_type  stage_in [NUM_W+1];

   // one restoring step: bring down the next numerator bit, subtract if it fits
   function automatic div_stage_type div_step(input div_stage_type cur);
      div_stage_type    nxt;
      logic [DEN_W:0]   shifted;
      logic [DEN_W:0]   diff;
      logic             fits;
      nxt     = cur;
      shifted = {cur.rem, cur.nq[NUM_W-1]};
      diff    = shifted - {1'b0, cur.den};
      fits    = shifted >= {1'b0, cur.den};
      nxt.rem = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      nxt.nq  = {cur.nq[NUM_W-2:0], fits};
      return nxt;
   endfunction

   // load stage zero, step every later stage
   always_comb begin
      stage_in[0] = '{rem: '0, nq: in_num, den: in_den, side: in_side};
      for (int j = 0; j < NUM_W; j++) begin
         stage_in[j+1] = div_step(stage_ff[j]);
      end
      valid_in = {valid_ff[NUM_W-1:0], in_valid};
   end

   // advance all stages together, hold on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quot  = stage_ff[NUM_W].nq;
   assign out_side  = stage_ff[NUM_W].side;

endmodule

FILE: rtl/core/plc_checker.sv
// Port-level assertions for the calibration block, bound to its top level.
module plc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input plc_pkg::rsp_type rsp_item
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // hold a stalled result
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_item))
      else $error("result changed while stalled");

   // plain scaling is never negative and never clamps
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.used_fallback |-> !rsp_item.saturated && !rsp_item.step_count[31])
      else $error("fallback result negative or clamped");

   // a clamped result sits on a bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.saturated |->
         (rsp_item.step_count == $signed(plc_pkg::COUNT_MAX))
         || (rsp_item.step_count == $signed(plc_pkg::COUNT_MIN)))
      else $error("clamped result off the 32-bit bounds");

endmodule

bind piecewise_linear_calibration plc_checker u_plc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_item  (rsp_if.payload)
);
